// ===== design/mesh_feature_volume_accumulator_core_assert.svh =====
// Assertion macros used by the accumulator core design file.
// Each macro compiles to a concurrent assertion in simulation and to nothing
// in synthesis.
`ifndef MESH_FEATURE_VOLUME_ACCUMULATOR_CORE_ASSERT_SVH
`define MESH_FEATURE_VOLUME_ACCUMULATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// Check that prop holds at every rising edge outside reset.
`define MFVA_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("mfva assertion failed");
// Check that cond never holds at a rising edge outside reset.
`define MFVA_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
        else $error("mfva forbidden condition seen");
`else
`define MFVA_ASSERT(lbl, clk, rstn, prop)
`define MFVA_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== design/mfva_pkg.sv =====
package mfva_pkg;

    // Feature store
    localparam int NUM_FEATURES = 1024;
    localparam int ADDR_W       = $clog2(NUM_FEATURES);

    // Field widths
    localparam int COORD_W   = 16;
    localparam int LABEL_W   = 11;
    localparam int RLABEL_W  = 10;
    localparam int SUM_W     = 64;
    localparam int VOL_W     = 62;

    // Triple product datapath widths
    localparam int DIFF_W    = COORD_W + 1;          // vertex differences
    localparam int MINOR_W   = 2 * DIFF_W + 1;       // 2x2 minors
    localparam int PROD_W    = DIFF_W + MINOR_W;     // shared multiplier output
    localparam int DET_W     = PROD_W + 2;           // sum of three products

    // Divisor that turns six-fold volume into volume
    localparam int DIVISOR   = 6;

    // Stream widths
    localparam int TRI_W      = 9 * COORD_W;
    localparam int S_TDATA_W  = ((TRI_W + 2 * LABEL_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((RLABEL_W + VOL_W + 7) / 8) * 8;

    // One vertex, x in the lowest bits
    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } vertex_t;

    // One triangle, v0 in the lowest bits
    typedef struct packed {
        vertex_t v2;
        vertex_t v1;
        vertex_t v0;
    } triangle_t;

    // Status of an iterative arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

// ===== design/mfva_triple.sv =====
module mfva_triple (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  mfva_pkg::triangle_t                   tri_in,
    output mfva_pkg::unit_status_t                status,
    output logic signed [mfva_pkg::DET_W-1:0]     det
);
    import mfva_pkg::*;

    localparam logic [3:0] LAST_STEP = 4'd9;

    logic                      run_reg;
    logic [3:0]                step_reg;
    logic signed [DIFF_W-1:0]  ax_reg, ay_reg, az_reg;
    logic signed [DIFF_W-1:0]  bx_reg, by_reg, bz_reg;
    logic signed [DIFF_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic signed [MINOR_W-1:0] m0_reg, m1_reg, m2_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [DET_W-1:0]   det_reg;

    logic signed [DIFF_W-1:0]  mul_a;
    logic signed [MINOR_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_full;

    // Select the operands of the shared multiplier for this step
    always_comb begin
        unique case (step_reg)
            4'd0: begin mul_a = by_reg; mul_b = MINOR_W'(cz_reg); end
            4'd1: begin mul_a = cy_reg; mul_b = MINOR_W'(bz_reg); end
            4'd2: begin mul_a = ay_reg; mul_b = MINOR_W'(cz_reg); end
            4'd3: begin mul_a = cy_reg; mul_b = MINOR_W'(az_reg); end
            4'd4: begin mul_a = ay_reg; mul_b = MINOR_W'(bz_reg); end
            4'd5: begin mul_a = by_reg; mul_b = MINOR_W'(az_reg); end
            4'd6: begin mul_a = ax_reg; mul_b = m0_reg;           end
            4'd7: begin mul_a = bx_reg; mul_b = m1_reg;           end
            4'd8: begin mul_a = cx_reg; mul_b = m2_reg;           end
            default: begin mul_a = '0; mul_b = '0;                end
        endcase
    end

    assign prod_full = mul_a * mul_b;

    // Sequence control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end else if (start) begin
            run_reg  <= 1'b1;
            step_reg <= '0;
        end else if (run_reg) begin
            step_reg <= step_reg + 4'd1;
            if (step_reg == LAST_STEP) begin
                run_reg <= 1'b0;
            end
        end
    end

    // Latch edge vectors, then multiply one pair and fold the previous product per cycle
    always_ff @(posedge aclk) begin
        if (start) begin
            ax_reg <= DIFF_W'(tri_in.v1.x) - DIFF_W'(tri_in.v0.x);
            ay_reg <= DIFF_W'(tri_in.v1.y) - DIFF_W'(tri_in.v0.y);
            az_reg <= DIFF_W'(tri_in.v1.z) - DIFF_W'(tri_in.v0.z);
            bx_reg <= DIFF_W'(tri_in.v2.x) - DIFF_W'(tri_in.v0.x);
            by_reg <= DIFF_W'(tri_in.v2.y) - DIFF_W'(tri_in.v0.y);
            bz_reg <= DIFF_W'(tri_in.v2.z) - DIFF_W'(tri_in.v0.z);
            cx_reg <= -DIFF_W'(tri_in.v0.x);
            cy_reg <= -DIFF_W'(tri_in.v0.y);
            cz_reg <= -DIFF_W'(tri_in.v0.z);
        end else if (run_reg) begin
            prod_reg <= prod_full;
            case (step_reg)
                4'd1: m0_reg  <= MINOR_W'(prod_reg);
                4'd2: m0_reg  <= m0_reg - MINOR_W'(prod_reg);
                4'd3: m1_reg  <= MINOR_W'(prod_reg);
                4'd4: m1_reg  <= m1_reg - MINOR_W'(prod_reg);
                4'd5: m2_reg  <= MINOR_W'(prod_reg);
                4'd6: m2_reg  <= m2_reg - MINOR_W'(prod_reg);
                4'd7: det_reg <= DET_W'(prod_reg);
                4'd8: det_reg <= det_reg - DET_W'(prod_reg);
                4'd9: det_reg <= det_reg + DET_W'(prod_reg);
                default: begin
                end
            endcase
        end
    end

    assign status.busy = run_reg;
    assign status.done = run_reg && (step_reg == LAST_STEP);
    assign det         = det_reg;

endmodule

// ===== design/mfva_div6.sv =====
module mfva_div6 (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  start,
    input  logic signed [mfva_pkg::SUM_W-1:0]     dividend,
    output mfva_pkg::unit_status_t                status,
    output logic signed [mfva_pkg::VOL_W-1:0]     quotient
);
    import mfva_pkg::*;

    // Long division in 16-bit digits, most significant digit first
    localparam int DIGIT_W     = 16;
    localparam int NUM_DIGITS  = SUM_W / DIGIT_W;
    localparam int CNT_W       = $clog2(NUM_DIGITS);
    localparam int REM_W       = $clog2(DIVISOR);
    localparam int PART_W      = REM_W + DIGIT_W;
    localparam int RECIP_SHIFT = 21;
    localparam logic [PART_W-1:0] RECIP =
        PART_W'((2 ** RECIP_SHIFT + DIVISOR - 1) / DIVISOR);

    logic                 run_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 neg_reg;
    logic [SUM_W-1:0]     mag_reg;
    logic [REM_W-1:0]     rem_reg;

    logic [PART_W-1:0]    part;
    logic [2*PART_W-1:0]  prod;
    logic [DIGIT_W-1:0]   q_digit;
    logic [PART_W-1:0]    q_times;
    logic [REM_W-1:0]     rem_next;
    logic [SUM_W-1:0]     q_full;

    // One digit step: bring down the next digit behind the remainder and divide
    // by six with a reciprocal multiply, exact for every partial dividend below 6 * 2^16
    assign part     = {rem_reg, mag_reg[SUM_W-1 -: DIGIT_W]};
    assign prod     = (2*PART_W)'(part) * (2*PART_W)'(RECIP);
    assign q_digit  = prod[RECIP_SHIFT +: DIGIT_W];
    assign q_times  = PART_W'(q_digit) * PART_W'(DIVISOR);
    assign rem_next = REM_W'(part - q_times);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end else if (start) begin
            run_reg <= 1'b1;
            cnt_reg <= '0;
        end else if (run_reg) begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (cnt_reg == CNT_W'(NUM_DIGITS - 1)) begin
                run_reg <= 1'b0;
            end
        end
    end

    // Shift the magnitude out at the top and the quotient digits in at the bottom
    always_ff @(posedge aclk) begin
        if (start) begin
            neg_reg <= dividend[SUM_W-1];
            mag_reg <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
            rem_reg <= '0;
        end else if (run_reg) begin
            mag_reg <= {mag_reg[SUM_W-DIGIT_W-1:0], q_digit};
            rem_reg <= rem_next;
        end
    end

    // Restore the sign: truncation toward zero
    assign q_full      = neg_reg ? (~mag_reg + SUM_W'(1)) : mag_reg;
    assign quotient    = q_full[VOL_W-1:0];
    assign status.busy = run_reg;
    assign status.done = run_reg && (cnt_reg == CNT_W'(NUM_DIGITS - 1));

endmodule

// ===== design/mesh_feature_volume_accumulator_core.sv =====
// Per-feature enclosed volume of a closed triangle mesh. An add transaction (s_tuser = 0)
// carries one triangle and its front and back labels; the block forms the exact triple
// product of (v1-v0, v2-v0, -v0) with one shared 17x35 multiplier, then adds it to the
// 64-bit saturating sum of label_a and subtracts it from that of label_b, each a
// read-modify-write on one single-port 1024x64 memory. Labels of -1 or outside the store
// are skipped. s_tready stays low until an add has finished its updates. A read
// transaction (s_tuser = 1) returns label_a and its sum divided by six, truncated toward
// zero, in units of 2^-24; the division runs one 16-bit quotient digit per cycle by
// reciprocal multiplication, four digits in all, and the next transaction is accepted only
// once the result is loaded into the output register, after any wait for the previous
// result to be taken. A read of an invalid label returns nothing.
// After reset the block clears all 1024 entries of the memory one entry per cycle, and
// s_tready stays low during that pass.
`include "mesh_feature_volume_accumulator_core_assert.svh"

module mesh_feature_volume_accumulator_core (
    input  logic                               aclk,
    input  logic                               aresetn,
    // s_tdata, from bit 0: v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    // label_a, label_b, zero fill
    input  logic [mfva_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: kind
    input  logic                               s_tuser,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // m_tdata, from bit 0: read_label, volume
    output logic [mfva_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready
);
    import mfva_pkg::*;

    localparam logic [3:0] ST_CLEAR  = 4'd0;
    localparam logic [3:0] ST_IDLE   = 4'd1;
    localparam logic [3:0] ST_MUL    = 4'd2;
    localparam logic [3:0] ST_RD_A   = 4'd3;
    localparam logic [3:0] ST_WR_A   = 4'd4;
    localparam logic [3:0] ST_RD_B   = 4'd5;
    localparam logic [3:0] ST_WR_B   = 4'd6;
    localparam logic [3:0] ST_RD_Q   = 4'd7;
    localparam logic [3:0] ST_LOAD_Q = 4'd8;
    localparam logic [3:0] ST_DIV    = 4'd9;
    localparam logic [3:0] ST_OUT    = 4'd10;

    localparam logic KIND_ADD  = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

    // Label is a usable store index
    function automatic logic label_ok(input logic signed [LABEL_W-1:0] lab);
        logic [LABEL_W:0] mag;
        mag = {1'b0, lab};
        return !lab[LABEL_W-1] && (mag < (LABEL_W+1)'(NUM_FEATURES));
    endfunction

    // Saturating 64-bit add of a sign-extended determinant
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] a,
        input logic signed [DET_W-1:0] b
    );
        logic signed [SUM_W:0] s;
        s = (SUM_W+1)'(a) + (SUM_W+1)'(b);
        if (s[SUM_W] != s[SUM_W-1]) begin
            return s[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return s[SUM_W-1:0];
    endfunction

    logic [3:0]                 state_reg, state_next;
    logic [ADDR_W-1:0]          clr_idx_reg;
    logic signed [LABEL_W-1:0]  la_reg, lb_reg;
    logic                       la_ok_reg, lb_ok_reg;
    logic                       m_valid_reg;
    logic [RLABEL_W-1:0]        m_label_reg;
    logic signed [VOL_W-1:0]    m_volume_reg;

    logic [SUM_W-1:0]           mem [NUM_FEATURES];
    logic signed [SUM_W-1:0]    mem_rd_reg;
    logic [ADDR_W-1:0]          mem_addr;
    logic                       mem_we;
    logic signed [SUM_W-1:0]    mem_wdata;

    logic                       s_accept;
    logic                       out_load;
    triangle_t                  tri_in;
    logic signed [LABEL_W-1:0]  s_label_a, s_label_b;
    logic                       tri_start, div_start;
    unit_status_t               tri_stat, div_stat;
    logic signed [DET_W-1:0]    det;
    logic signed [VOL_W-1:0]    quotient;

    // Unpack the input transaction
    assign tri_in    = triangle_t'(s_tdata[TRI_W-1:0]);
    assign s_label_a = s_tdata[TRI_W +: LABEL_W];
    assign s_label_b = s_tdata[TRI_W + LABEL_W +: LABEL_W];

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign tri_start = s_accept && (s_tuser == KIND_ADD);
    assign div_start = (state_reg == ST_LOAD_Q);
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_tready);

    mfva_triple u_triple (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (tri_start),
        .tri_in  (tri_in),
        .status  (tri_stat),
        .det     (det)
    );

    mfva_div6 u_div6 (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mem_rd_reg),
        .status   (div_stat),
        .quotient (quotient)
    );

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_idx_reg == ADDR_W'(NUM_FEATURES - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_accept) begin
                    if (s_tuser == KIND_READ) begin
                        state_next = label_ok(s_label_a) ? ST_RD_Q : ST_IDLE;
                    end else begin
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL: begin
                if (tri_stat.done) begin
                    priority if (la_ok_reg) state_next = ST_RD_A;
                    else if (lb_ok_reg)     state_next = ST_RD_B;
                    else                    state_next = ST_IDLE;
                end
            end
            ST_RD_A:   state_next = ST_WR_A;
            ST_WR_A:   state_next = lb_ok_reg ? ST_RD_B : ST_IDLE;
            ST_RD_B:   state_next = ST_WR_B;
            ST_WR_B:   state_next = ST_IDLE;
            ST_RD_Q:   state_next = ST_LOAD_Q;
            ST_LOAD_Q: state_next = ST_DIV;
            ST_DIV: begin
                if (div_stat.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_idx_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_idx_reg <= clr_idx_reg + ADDR_W'(1);
            end
        end
    end

    // Hold the labels of the accepted transaction
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            la_reg    <= s_label_a;
            lb_reg    <= s_label_b;
            la_ok_reg <= label_ok(s_label_a);
            lb_ok_reg <= label_ok(s_label_b);
        end
    end

    // Memory port: address, write enable and saturated update
    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_addr = clr_idx_reg;
                mem_we   = 1'b1;
            end
            ST_RD_A, ST_RD_Q, ST_LOAD_Q: begin
                mem_addr = la_reg[ADDR_W-1:0];
            end
            ST_WR_A: begin
                mem_addr  = la_reg[ADDR_W-1:0];
                mem_we    = 1'b1;
                mem_wdata = sat_add(mem_rd_reg, det);
            end
            ST_RD_B: begin
                mem_addr = lb_reg[ADDR_W-1:0];
            end
            ST_WR_B: begin
                mem_addr  = lb_reg[ADDR_W-1:0];
                mem_we    = 1'b1;
                mem_wdata = sat_add(mem_rd_reg, -det);
            end
            default: begin
                mem_addr = la_reg[ADDR_W-1:0];
            end
        endcase
    end

    // Single-port volume store with registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        mem_rd_reg <= mem[mem_addr];
    end

    // Output register: drop on take, load when the slot is free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_label_reg  <= la_reg[RLABEL_W-1:0];
            m_volume_reg <= quotient;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_volume_reg, m_label_reg});

    // A result only appears after a read finished its division
    `MFVA_ASSERT(a_result_from_read, aclk, aresetn, $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
    // Never update a sum through a label that was rejected
    `MFVA_NEVER(a_no_bad_write_a, aclk, aresetn, (state_reg == ST_WR_A) && !la_ok_reg)
    `MFVA_NEVER(a_no_bad_write_b, aclk, aresetn, (state_reg == ST_WR_B) && !lb_ok_reg)
    // Arithmetic units finish only while the sequencer waits on them
    `MFVA_ASSERT(a_tri_done_in_mul, aclk, aresetn, tri_stat.done |-> state_reg == ST_MUL)
    `MFVA_ASSERT(a_div_done_in_div, aclk, aresetn, div_stat.done |-> state_reg == ST_DIV)

endmodule
